>>> src/emoji_skin_tone_inserter_unit_defines.svh
// Assertion macros for the emoji skin-tone inserter.
// Uses clk and rst_n of the module that takes this header.
`ifndef EMOJI_SKIN_TONE_INSERTER_UNIT_DEFINES_SVH
`define EMOJI_SKIN_TONE_INSERTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define EST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("est: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define EST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("est: next-cycle check failed");

`endif

>>> src/est_pkg.sv
// Shared types and constants for the emoji skin-tone inserter.
// No dependencies.
`default_nettype none
package est_pkg;

  localparam int TONE_W     = 3;
  localparam int MAX_BYTES  = 8;
  localparam int IDX_W      = 3;
  localparam int CNT_W      = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  // Register index of skin_tone
  localparam logic REG_SKIN_TONE = 1'b0;

  // Skin-tone modifier F0 9F 8F BB+tone
  localparam logic [7:0] TONE_B0   = 8'hF0;
  localparam logic [7:0] TONE_B1   = 8'h9F;
  localparam logic [7:0] TONE_B2   = 8'h8F;
  localparam logic [7:0] TONE_BASE = 8'hBB;
  localparam logic [TONE_W-1:0] TONE_MAX = 3'd4;

  // Variation selector EF B8 8F
  localparam logic [7:0] VS_B0 = 8'hEF;
  localparam logic [7:0] VS_B1 = 8'hB8;
  localparam logic [7:0] VS_B2 = 8'h8F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_end;
    logic       string_end;
  } out_item_t;

  // Work for the back end: bytes to send for one input beat
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic                      last;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_COLLECT = 3'b001,
    PH_STRIP   = 3'b010,
    PH_PASS    = 3'b100
  } phase_t;

endpackage
`default_nettype wire

>>> src/est_front.sv
// Front end: accepts input beats, validates the first code point, appends the
// skin-tone modifier, strips U+FE0F. Depends on est_pkg; feeds est_fifo.
`default_nettype none
module est_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  est_pkg::in_item_t          in_data,
  input  logic [est_pkg::TONE_W-1:0] skin_tone,
  input  logic                       q_full,
  output logic                       q_push,
  output est_pkg::cmd_t              q_cmd
);

  est_pkg::phase_t phase_r, phase_nxt;
  logic [3:0][7:0] held_r, held_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [2:0]      need_r, need_nxt;
  logic [1:0]      match_r, match_nxt;
  est_pkg::cmd_t   cmd;
  logic            fire;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign q_cmd    = cmd;
  assign q_push   = fire && ((cmd.count != '0) || in_data.is_last);

  // Build the byte list for this beat and the next state
  always_comb begin : front_logic
    logic [est_pkg::CNT_W-1:0] n;
    logic [7:0]                b;
    logic [7:0]                tone_b;
    logic [7:0]                lo;
    logic [7:0]                hi;
    logic                      skip;
    b      = in_data.data_byte;
    tone_b = est_pkg::TONE_BASE + ((skin_tone > est_pkg::TONE_MAX) ?
             8'(est_pkg::TONE_MAX) : 8'(skin_tone));
    n         = '0;
    skip      = 1'b0;
    cmd       = '0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    need_nxt  = need_r;
    match_nxt = match_r;
    // continuation range, narrowed on the second byte for some leads
    lo = 8'h80;
    hi = 8'hBF;
    if (cnt_r == 3'd1) begin
      if (held_r[0] == 8'hE0) lo = 8'hA0;
      else if (held_r[0] == 8'hED) hi = 8'h9F;
      else if (held_r[0] == 8'hF0) lo = 8'h90;
      else if (held_r[0] == 8'hF4) hi = 8'h8F;
    end
    unique case (phase_r)
      est_pkg::PH_COLLECT: begin
        if (cnt_r == 3'd0) begin
          if (b < 8'h80) begin
            cmd.bytes[n[2:0]] = b;                n = n + 4'd1;
            cmd.bytes[n[2:0]] = est_pkg::TONE_B0; n = n + 4'd1;
            cmd.bytes[n[2:0]] = est_pkg::TONE_B1; n = n + 4'd1;
            cmd.bytes[n[2:0]] = est_pkg::TONE_B2; n = n + 4'd1;
            cmd.bytes[n[2:0]] = tone_b;           n = n + 4'd1;
            phase_nxt = est_pkg::PH_STRIP;
          end else if (b >= 8'hC2 && b <= 8'hF4) begin
            held_nxt[0] = b;
            cnt_nxt     = 3'd1;
            need_nxt    = (b < 8'hE0) ? 3'd2 : ((b < 8'hF0) ? 3'd3 : 3'd4);
          end else begin
            cmd.bytes[n[2:0]] = b; n = n + 4'd1;
            phase_nxt = est_pkg::PH_PASS;
          end
        end else if (b >= lo && b <= hi) begin
          if (cnt_r + 3'd1 >= need_r) begin
            // code point complete: send it and the modifier
            for (int k = 0; k < 4; k++) begin
              if (3'(k) < cnt_r) begin
                cmd.bytes[n[2:0]] = held_r[k]; n = n + 4'd1;
              end
            end
            cmd.bytes[n[2:0]] = b;                n = n + 4'd1;
            cmd.bytes[n[2:0]] = est_pkg::TONE_B0; n = n + 4'd1;
            cmd.bytes[n[2:0]] = est_pkg::TONE_B1; n = n + 4'd1;
            cmd.bytes[n[2:0]] = est_pkg::TONE_B2; n = n + 4'd1;
            cmd.bytes[n[2:0]] = tone_b;           n = n + 4'd1;
            cnt_nxt   = 3'd0;
            phase_nxt = est_pkg::PH_STRIP;
          end else begin
            held_nxt[cnt_r[1:0]] = b;
            cnt_nxt = cnt_r + 3'd1;
          end
        end else begin
          // bad continuation: release everything, pass the rest through
          for (int k = 0; k < 4; k++) begin
            if (3'(k) < cnt_r) begin
              cmd.bytes[n[2:0]] = held_r[k]; n = n + 4'd1;
            end
          end
          cmd.bytes[n[2:0]] = b; n = n + 4'd1;
          cnt_nxt   = 3'd0;
          phase_nxt = est_pkg::PH_PASS;
        end
        // string cut short inside the first code point
        if (in_data.is_last && phase_nxt == est_pkg::PH_COLLECT && cnt_nxt != 3'd0) begin
          for (int k = 0; k < 4; k++) begin
            if (3'(k) < cnt_nxt) begin
              cmd.bytes[n[2:0]] = held_nxt[k]; n = n + 4'd1;
            end
          end
          cnt_nxt = 3'd0;
        end
      end
      est_pkg::PH_STRIP: begin
        if (match_r == 2'd1) begin
          if (b == est_pkg::VS_B1) begin
            match_nxt = 2'd2;
            skip      = 1'b1;
          end else begin
            cmd.bytes[n[2:0]] = est_pkg::VS_B0; n = n + 4'd1;
          end
        end else if (match_r == 2'd2) begin
          if (b == est_pkg::VS_B2) begin
            match_nxt = 2'd0;
            skip      = 1'b1;
          end else begin
            cmd.bytes[n[2:0]] = est_pkg::VS_B0; n = n + 4'd1;
            cmd.bytes[n[2:0]] = est_pkg::VS_B1; n = n + 4'd1;
          end
        end
        if (!skip) begin
          if (b == est_pkg::VS_B0) begin
            match_nxt = 2'd1;
          end else begin
            match_nxt = 2'd0;
            cmd.bytes[n[2:0]] = b; n = n + 4'd1;
          end
        end
      end
      est_pkg::PH_PASS: begin
        cmd.bytes[n[2:0]] = b; n = n + 4'd1;
      end
      default: begin
        phase_nxt = est_pkg::PH_COLLECT;
      end
    endcase
    // end of string: flush a partial selector and return to the start
    if (in_data.is_last) begin
      if (phase_nxt == est_pkg::PH_STRIP) begin
        if (match_nxt >= 2'd1) begin
          cmd.bytes[n[2:0]] = est_pkg::VS_B0; n = n + 4'd1;
        end
        if (match_nxt >= 2'd2) begin
          cmd.bytes[n[2:0]] = est_pkg::VS_B1; n = n + 4'd1;
        end
      end
      phase_nxt = est_pkg::PH_COLLECT;
      cnt_nxt   = 3'd0;
      need_nxt  = 3'd0;
      match_nxt = 2'd0;
    end
    cmd.count = n;
    cmd.last  = in_data.is_last;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= est_pkg::PH_COLLECT;
      cnt_r   <= '0;
      need_r  <= '0;
      match_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      need_r  <= need_nxt;
      match_r <= match_nxt;
    end
  end

  // Held lead and continuation bytes
  always_ff @(posedge clk) begin
    if (fire) begin
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/est_fifo.sv
// Short command queue between front and back end.
// Depends on est_pkg for the command type.
`default_nettype none
module est_fifo #(
  parameter int DEPTH = est_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  est_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output est_pkg::cmd_t head_cmd,
  output logic          head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  est_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0] level_r;
  logic             do_push, do_pop;

  assign full       = (level_r == LVL_W'(DEPTH));
  assign head_valid = (level_r != '0);
  assign head_cmd   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        level_r <= level_r + 1'b1;
      end else if (do_pop && !do_push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/est_back.sv
// Back end: serializes queued commands into output beats, one byte a cycle while out_ready allows.
// Depends on est_pkg; drains est_fifo.
`default_nettype none
module est_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  est_pkg::cmd_t      head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output est_pkg::out_item_t out_data
);

  logic [est_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      out_valid_r;
  est_pkg::out_item_t        out_data_r, out_data_nxt;
  logic                      load, last_byte, has_bytes;

  assign has_bytes = (head_cmd.count != '0);
  assign last_byte = !has_bytes ||
                     ({1'b0, idx_r} == head_cmd.count - est_pkg::CNT_W'(1));
  assign load      = head_valid && (!out_valid_r || out_ready);
  assign pop       = load && last_byte;
  assign idx_nxt   = last_byte ? '0 : idx_r + 1'b1;

  // Pick the current byte of the head command
  always_comb begin
    out_data_nxt.out_byte   = has_bytes ? head_cmd.bytes[idx_r] : 8'h00;
    out_data_nxt.byte_valid = has_bytes;
    out_data_nxt.run_end    = last_byte;
    out_data_nxt.string_end = last_byte && head_cmd.last;
  end

  // Output register and byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= idx_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold payload until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> src/emoji_skin_tone_inserter_unit.sv
// Top level of the emoji skin-tone inserter: config register, front, queue, back.
// Depends on est_pkg, est_front, est_fifo, est_back and the defines header.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_valid/in_ready   | in_data  (data_byte, is_last)
//  out_    | out | out_valid/out_ready | out_data (out_byte, byte_valid, run_end,
//          |     |                     |           string_end)
//  cfg_    | in  | APB psel/penable    | skin_tone at byte address 0
//
// The front end takes one byte per cycle while the command queue has room.
// The back end sends one output beat per cycle from the queue head while
// out_ready is high; an input byte yields zero to eight beats, so bursts
// after the first code point fill the queue and stall input until it drains.
// Synchronous reset clears all control state; no clearing pass.
`default_nettype none
`include "emoji_skin_tone_inserter_unit_defines.svh"
module emoji_skin_tone_inserter_unit #(
  parameter int QDEPTH = est_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  est_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output est_pkg::out_item_t         out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [est_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [est_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [est_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [est_pkg::TONE_W-1:0] skin_tone_r;
  logic                       cfg_wr, q_full, q_push, q_pop, q_valid;
  est_pkg::cmd_t              q_cmd, q_head;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == est_pkg::REG_SKIN_TONE);
  assign cfg_prdata = (cfg_paddr[2] == est_pkg::REG_SKIN_TONE) ?
                      est_pkg::DATA_W'(skin_tone_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skin_tone_r <= '0;
    end else if (cfg_wr) begin
      skin_tone_r <= cfg_pwdata[est_pkg::TONE_W-1:0];
    end
  end

  est_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .skin_tone (skin_tone_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  est_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_cmd   (q_head),
    .head_valid (q_valid)
  );

  est_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Checks
  `EST_ASSERT_NOW(a_bare_marker_ends, out_valid && !out_data.byte_valid, out_data.run_end && out_data.string_end)
  `EST_ASSERT_NOW(a_string_end_run_end, out_valid && out_data.string_end, out_data.run_end)
  `EST_ASSERT_NOW(a_full_has_work, !in_ready, q_valid && out_valid)
  `EST_ASSERT_NEXT(a_push_fills, q_push && !q_pop, q_valid)

endmodule
`default_nettype wire
